@@ hdl/wms_pkg.sv @@
// Shared types and constants for the weighted mean / standard deviation block.
package wms_pkg;
	localparam int FEATURES_MAX = 16;
	localparam int IDX_W        = $clog2(FEATURES_MAX);
	localparam int FC_W         = 5;
	localparam int FIFO_DEPTH   = 4;
	localparam int PTR_W        = $clog2(FIFO_DEPTH);
	localparam int CNT_W        = PTR_W + 1;

	localparam logic [15:0] ONE_Q8 = 16'd256;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ZERO_W = 2'd1;
	localparam logic [1:0] ST_DEN    = 2'd2;
	localparam logic [1:0] ST_SAT    = 2'd3;

	typedef struct packed {
		logic signed [15:0] value;
		logic [15:0]        weight;
		logic [IDX_W-1:0]   pos;
		logic               eos;
		logic [FC_W-1:0]    fc;
	} wms_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} wms_fifo_stat_t;
endpackage

@@ hdl/wms_front.sv @@
// Input side: feature count register, position tracking and item classification.
module wms_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [4:0]            cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // value [15:0], weight [31:16]
	input  logic                  s_tlast,   // end_of_set
	input  wms_pkg::wms_fifo_stat_t fifo_stat,
	output logic                  push,
	output wms_pkg::wms_item_t    push_item
);
	import wms_pkg::*;

	logic [FC_W-1:0]  fc_q;
	logic [FC_W-1:0]  fc_eff;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] pos;
	logic [FC_W-1:0]  pos_inc;

	always_comb begin
		if (fc_q == '0)
			fc_eff = FC_W'(1);
		else if (fc_q > FC_W'(FEATURES_MAX))
			fc_eff = FC_W'(FEATURES_MAX);
		else
			fc_eff = fc_q;
	end

	// a shrunk count restarts the sample
	assign pos     = ({1'b0, pos_q} >= fc_eff) ? '0 : pos_q;
	assign pos_inc = {1'b0, pos} + FC_W'(1);

	assign s_tready = !fifo_stat.full;
	assign push     = s_tvalid && !fifo_stat.full;

	always_comb begin
		push_item.value  = s_tdata[15:0];
		push_item.weight = s_tdata[31:16];
		push_item.pos    = pos;
		push_item.eos    = s_tlast;
		push_item.fc     = fc_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q  <= FC_W'(1);
			pos_q <= '0;
		end else begin
			if (cfg_we)
				fc_q <= cfg_wdata;
			if (push) begin
				if (pos_inc >= fc_eff || s_tlast)
					pos_q <= '0;
				else
					pos_q <= pos_inc[IDX_W-1:0];
			end
		end
	end
endmodule

@@ hdl/wms_fifo.sv @@
// Short item queue between the front and the back.
module wms_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  wms_pkg::wms_item_t      push_item,
	input  logic                    pop,
	output wms_pkg::wms_item_t      pop_item,
	output wms_pkg::wms_fifo_stat_t stat
);
	import wms_pkg::*;

	wms_item_t        mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + PTR_W'(1);
			if (pop)
				rd_q <= rd_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end
endmodule

@@ hdl/wms_back.sv @@
// Back end: accumulation per value and the per-feature finalize sequencer.
module wms_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  wms_pkg::wms_fifo_stat_t fifo_stat,
	input  wms_pkg::wms_item_t      pop_item,
	output logic                    pop,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [39:0]             m_tdata,  // feature_index [3:0], mean [19:4],
	                                          // std_dev [35:20], status [37:36]
	output logic                    m_tlast
);
	import wms_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_ACC1    = 4'd1;
	localparam logic [3:0] S_ACC2    = 4'd2;
	localparam logic [3:0] S_FSTART  = 4'd3;
	localparam logic [3:0] S_MDIV    = 4'd4;
	localparam logic [3:0] S_MEAN    = 4'd5;
	localparam logic [3:0] S_MUL_WSQ = 4'd6;
	localparam logic [3:0] S_CHK_DEN = 4'd7;
	localparam logic [3:0] S_MUL_NA  = 4'd8;
	localparam logic [3:0] S_LOAD_NB = 4'd9;
	localparam logic [3:0] S_MUL_NB  = 4'd10;
	localparam logic [3:0] S_CHK_NUM = 4'd11;
	localparam logic [3:0] S_VDIV    = 4'd12;
	localparam logic [3:0] S_SQRT    = 4'd13;
	localparam logic [3:0] S_EMIT    = 4'd14;

	logic [3:0] state_q;
	wms_item_t  item_q;

	// accumulators
	logic [47:0]        tw_q;
	logic [63:0]        tw2_q;
	logic signed [63:0] sx_q  [FEATURES_MAX];
	logic [63:0]        sxx_q [FEATURES_MAX];

	// load pipeline
	logic signed [32:0] pwx_s1;
	logic [31:0]        psq_s1;
	logic [31:0]        pww_s1;
	logic [15:0]        ax;
	logic signed [16:0] xs;

	// finalize
	logic [FC_W-1:0]  j_q;
	logic [IDX_W-1:0] jx;
	logic [63:0]      mag_q;
	logic             neg_q;
	logic [15:0]      mean_q;
	logic [15:0]      std_q;
	logic [1:0]       stat_q;
	logic [95:0]      den_q;
	logic [127:0]     na_q;
	logic [5:0]       cnt_q;

	// shared shift-add multiplier
	logic [127:0] mul_a_q;
	logic [63:0]  mul_b_q;
	logic [127:0] mul_p_q;

	// shared restoring divider
	logic [95:0] div_rem_q;
	logic [63:0] div_dvd_q;
	logic [95:0] div_dsr_q;
	logic [63:0] div_quo_q;
	logic [96:0] div_rem2;
	logic        div_ge;
	logic [96:0] div_diff;

	// square root
	logic [15:0] sq_r_q;
	logic [15:0] sq_t;
	logic [31:0] sq_tt;
	logic [15:0] sq_next;

	// output register
	logic        out_valid_q;
	logic [3:0]  out_idx_q;
	logic [15:0] out_mean_q;
	logic [15:0] out_std_q;
	logic [1:0]  out_stat_q;
	logic        out_last_q;

	// combinational helpers
	logic [48:0]        tw_sum;
	logic [64:0]        tw2_sum;
	logic signed [64:0] sx_sum;
	logic [47:0]        wsq_prod;
	logic [64:0]        sxx_sum;
	logic signed [63:0] sx_j;
	logic [63:0]        mag_j;
	logic [63:0]        mq;
	logic [127:0]       num;
	logic               out_free;
	logic               last_feat;

	assign jx  = j_q[IDX_W-1:0];
	assign pop = (state_q == S_IDLE) && !fifo_stat.empty;

	assign xs = {item_q.value[15], item_q.value};
	assign ax = item_q.value[15] ? 16'(-xs) : 16'(xs);

	assign tw_sum   = {1'b0, tw_q} + {33'b0, item_q.weight};
	assign tw2_sum  = {1'b0, tw2_q} + {33'b0, pww_s1};
	assign sx_sum   = {sx_q[item_q.pos][63], sx_q[item_q.pos]} + 65'(pwx_s1);
	assign wsq_prod = item_q.weight * psq_s1;
	assign sxx_sum  = {1'b0, sxx_q[item_q.pos]} + {17'b0, wsq_prod};

	assign sx_j  = sx_q[jx];
	assign mag_j = sx_j[63] ? (64'd0 - 64'(sx_j)) : 64'(sx_j);
	assign mq    = div_quo_q;
	assign num   = na_q - mul_p_q;

	assign div_rem2 = {div_rem_q, div_dvd_q[63]};
	assign div_ge   = (div_rem2 >= {1'b0, div_dsr_q});
	assign div_diff = div_rem2 - {1'b0, div_dsr_q};

	assign sq_t    = sq_r_q | (16'h8000 >> cnt_q[3:0]);
	assign sq_tt   = sq_t * sq_t;
	assign sq_next = (sq_tt <= div_quo_q[31:0]) ? sq_t : sq_r_q;

	assign out_free  = !out_valid_q || m_tready;
	assign last_feat = (j_q + FC_W'(1) == item_q.fc);

	always_ff @(posedge clk) begin
		if (pop)
			item_q <= pop_item;
		if (state_q == S_ACC1) begin
			pwx_s1 <= $signed({1'b0, item_q.weight}) * xs;
			psq_s1 <= ax * ax;
			pww_s1 <= item_q.weight * item_q.weight;
		end
		if (state_q == S_MDIV || state_q == S_VDIV) begin
			div_rem_q <= div_ge ? div_diff[95:0] : div_rem2[95:0];
			div_dvd_q <= {div_dvd_q[62:0], 1'b0};
			div_quo_q <= {div_quo_q[62:0], div_ge};
		end
		if (state_q == S_MUL_WSQ || state_q == S_MUL_NA || state_q == S_MUL_NB) begin
			if (mul_b_q[0])
				mul_p_q <= mul_p_q + mul_a_q;
			mul_a_q <= {mul_a_q[126:0], 1'b0};
			mul_b_q <= {1'b0, mul_b_q[63:1]};
		end
		unique case (state_q)
			S_FSTART: begin
				mag_q     <= mag_j;
				neg_q     <= sx_j[63];
				stat_q    <= (tw_q == '0) ? ST_ZERO_W : ST_OK;
				div_rem_q <= '0;
				div_dvd_q <= mag_j + {17'b0, tw_q[47:1]};
				div_dsr_q <= {48'b0, tw_q};
				div_quo_q <= '0;
				if (tw_q == '0) begin
					mean_q <= '0;
					std_q  <= ONE_Q8;
				end
			end
			S_MEAN: begin
				if (!neg_q && mq > 64'd32767) begin
					mean_q <= 16'd32767;
					stat_q <= ST_SAT;
				end else if (neg_q && mq > 64'd32768) begin
					mean_q <= 16'h8000;
					stat_q <= ST_SAT;
				end else begin
					mean_q <= neg_q ? 16'(64'd0 - mq) : mq[15:0];
				end
				mul_a_q <= {80'b0, tw_q};
				mul_b_q <= {16'b0, tw_q};
				mul_p_q <= '0;
			end
			S_CHK_DEN: begin
				den_q   <= 96'(mul_p_q - {64'b0, tw2_q});
				mul_a_q <= {64'b0, sxx_q[jx]};
				mul_b_q <= {16'b0, tw_q};
				if ({64'b0, tw2_q} >= mul_p_q) begin
					std_q  <= ONE_Q8;
					stat_q <= ST_DEN;
				end
			end
			S_LOAD_NB: begin
				na_q    <= mul_p_q;
				mul_a_q <= {64'b0, mag_q};
				mul_b_q <= mag_q;
			end
			S_CHK_NUM: begin
				div_rem_q <= num[127:32];
				div_dvd_q <= {num[31:0], 32'b0};
				div_dsr_q <= den_q;
				div_quo_q <= '0;
				sq_r_q    <= '0;
				if (na_q < mul_p_q) begin
					std_q <= ONE_Q8;
				end else if (num[127:32] >= den_q) begin
					std_q  <= 16'hFFFF;
					stat_q <= ST_SAT;
				end
			end
			S_SQRT: begin
				sq_r_q <= sq_next;
				if (cnt_q == 6'd15)
					std_q <= (sq_next == '0) ? ONE_Q8 : sq_next;
			end
			default: begin
			end
		endcase
		if (state_q == S_CHK_DEN && {64'b0, tw2_q} < mul_p_q)
			mul_p_q <= '0;
		if (state_q == S_LOAD_NB)
			mul_p_q <= '0;
		if (state_q == S_EMIT && out_free) begin
			out_idx_q  <= jx;
			out_mean_q <= mean_q;
			out_std_q  <= std_q;
			out_stat_q <= stat_q;
			out_last_q <= last_feat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			j_q         <= '0;
			cnt_q       <= '0;
			tw_q        <= '0;
			tw2_q       <= '0;
			for (int i = 0; i < FEATURES_MAX; i++) begin
				sx_q[i]  <= '0;
				sxx_q[i] <= '0;
			end
		end else begin
			// a new result replaces the held one in S_EMIT
			if (m_tready && state_q != S_EMIT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop)
						state_q <= S_ACC1;
				end
				S_ACC1: state_q <= S_ACC2;
				S_ACC2: begin
					if (item_q.pos == '0) begin
						tw_q  <= tw_sum[48] ? '1 : tw_sum[47:0];
						tw2_q <= tw2_sum[64] ? '1 : tw2_sum[63:0];
					end
					if (sx_sum[64] != sx_sum[63])
						sx_q[item_q.pos] <= sx_sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
					else
						sx_q[item_q.pos] <= sx_sum[63:0];
					sxx_q[item_q.pos] <= sxx_sum[64] ? '1 : sxx_sum[63:0];
					j_q     <= '0;
					state_q <= item_q.eos ? S_FSTART : S_IDLE;
				end
				S_FSTART: begin
					cnt_q   <= '0;
					state_q <= (tw_q == '0) ? S_EMIT : S_MDIV;
				end
				S_MDIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63)
						state_q <= S_MEAN;
				end
				S_MEAN: begin
					cnt_q   <= '0;
					state_q <= S_MUL_WSQ;
				end
				S_MUL_WSQ: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63)
						state_q <= S_CHK_DEN;
				end
				S_CHK_DEN: begin
					cnt_q   <= '0;
					state_q <= ({64'b0, tw2_q} >= mul_p_q) ? S_EMIT : S_MUL_NA;
				end
				S_MUL_NA: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63)
						state_q <= S_LOAD_NB;
				end
				S_LOAD_NB: begin
					cnt_q   <= '0;
					state_q <= S_MUL_NB;
				end
				S_MUL_NB: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63)
						state_q <= S_CHK_NUM;
				end
				S_CHK_NUM: begin
					cnt_q <= '0;
					if (na_q < mul_p_q || num[127:32] >= den_q)
						state_q <= S_EMIT;
					else
						state_q <= S_VDIV;
				end
				S_VDIV: begin
					cnt_q <= (cnt_q == 6'd31) ? 6'd0 : cnt_q + 6'd1;
					if (cnt_q == 6'd31)
						state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd15)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						j_q         <= j_q + FC_W'(1);
						if (last_feat) begin
							tw_q  <= '0;
							tw2_q <= '0;
							for (int i = 0; i < FEATURES_MAX; i++) begin
								sx_q[i]  <= '0;
								sxx_q[i] <= '0;
							end
							state_q <= S_IDLE;
						end else begin
							state_q <= S_FSTART;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_stat_q, out_std_q, out_mean_q, out_idx_q};
	assign m_tlast  = out_last_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == S_IDLE)
		else $error("queue read outside idle");

	a_zero_w: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stat_q == ST_ZERO_W |-> out_mean_q == '0 && out_std_q == ONE_Q8)
		else $error("zero weight result malformed");

	a_std_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_std_q != '0)
		else $error("zero deviation on output");

	a_emit_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && out_valid_q && !m_tready |=> state_q == S_EMIT)
		else $error("result dropped while output stalled");
endmodule

@@ hdl/weighted_mean_stddev.sv @@
// Top level of the weighted mean and unbiased standard deviation block.
// Values stream in with their sample weight; a small queue decouples the input side from
// the arithmetic back end. Each value passes through three back-end steps (queue read,
// product stage, accumulate stage); the next value is read after the accumulate stage.
// On the value marked tlast, the back end finalizes each feature in turn using one shared
// 64-step shift-add multiplier, a shared restoring divider and a 16-step square root:
// a feature's finalize ends early when the total weight is zero or the
// denominator is not positive, and waits on m_tready. Input is stalled once the queue
// fills during a finalize burst.
module weighted_mean_stddev (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,  // feature_count
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // value [15:0], weight [31:16]
	input  logic        s_tlast,    // end_of_set
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,    // feature_index [3:0], mean [19:4], std_dev [35:20],
	                                // status [37:36]
	output logic        m_tlast     // last
);
	import wms_pkg::*;

	wms_fifo_stat_t fifo_stat;
	wms_item_t      push_item;
	wms_item_t      pop_item;
	logic           push;
	logic           pop;

	wms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.fifo_stat (fifo_stat),
		.push      (push),
		.push_item (push_item)
	);

	wms_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.stat      (fifo_stat)
	);

	wms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_stat (fifo_stat),
		.pop_item  (pop_item),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);
endmodule
